/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");

`endif

/* rtl/mdbsfr_pkg.sv */
// ----------------------------------------------------------------------------
// MDB slave frame receiver package
// Types, codes and constants shared by the receiver and its checker.
// ----------------------------------------------------------------------------
package mdbsfr_pkg;

  localparam int FRAME_LIMIT = 36;
  localparam int SLOT_COUNT  = 4;

  localparam logic [7:0] ADDR_MASK = 8'hF8;
  localparam logic [7:0] CMD_MASK  = 8'h07;
  localparam logic [7:0] ACK_BYTE  = 8'h00;

  localparam logic [1:0] STATUS_IDLE = 2'd0;
  localparam logic [1:0] STATUS_BUSY = 2'd1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RECV,
    PH_ACK
  } phase_e;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_RESET,
    CLS_SWITCH,
    CLS_CONTROL,
    CLS_POLL,
    CLS_COLUMN,
    CLS_STATUS
  } cls_e;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_ADDRESS  = 3'd1;
  localparam logic [2:0] EV_DATA     = 3'd2;
  localparam logic [2:0] EV_FRAME_OK = 3'd3;
  localparam logic [2:0] EV_CSUM_BAD = 3'd4;
  localparam logic [2:0] EV_OVERFLOW = 3'd5;
  localparam logic [2:0] EV_ACK_SEEN = 3'd6;
  localparam logic [2:0] EV_IGNORED  = 3'd7;

  localparam logic [2:0] RP_NONE   = 3'd0;
  localparam logic [2:0] RP_ACK    = 3'd1;
  localparam logic [2:0] RP_NAK    = 3'd2;
  localparam logic [2:0] RP_STATUS = 3'd3;
  localparam logic [2:0] RP_HOST   = 3'd4;

  localparam logic [2:0] JOB_NONE    = 3'd0;
  localparam logic [2:0] JOB_RESET   = 3'd1;
  localparam logic [2:0] JOB_SWITCH  = 3'd2;
  localparam logic [2:0] JOB_CONTROL = 3'd3;
  localparam logic [2:0] JOB_COLUMN  = 3'd4;
  localparam logic [2:0] JOB_STATUS  = 3'd5;

  localparam logic [2:0] CFG_CODE_RESET   = 3'd0;
  localparam logic [2:0] CFG_CODE_SWITCH  = 3'd1;
  localparam logic [2:0] CFG_CODE_CONTROL = 3'd2;
  localparam logic [2:0] CFG_CODE_POLL    = 3'd3;
  localparam logic [2:0] CFG_CODE_COLUMN  = 3'd4;
  localparam logic [2:0] CFG_CODE_STATUS  = 3'd5;

  function automatic logic [7:0] slot_addr(input logic [1:0] idx);
    logic [7:0] a;
    case (idx)
      2'd0:    a = 8'h80;
      2'd1:    a = 8'h88;
      2'd2:    a = 8'hE0;
      default: a = 8'hE8;
    endcase
    return a;
  endfunction

endpackage

/* rtl/mdb_slave_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// MDB slave frame receiver
// Tracks frames for four slave addresses on a 9-bit multi-drop bus, checks
// lengths and checksums, keeps slot status and produces one result per item.
// ----------------------------------------------------------------------------
// Each accepted item (bus byte or local status write) updates the link state
// in the cycle it is accepted and yields exactly one result, held in an
// output register and presented the next cycle. The block takes one item per
// clock: in_ready_o is high whenever the output register is empty or its
// result is taken in the same cycle, so the rate is set only by how fast the
// output side drains. Configuration writes are always ready.
module mdb_slave_frame_receiver_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [2:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] rx_byte_i,
  input  logic       mode_bit_i,
  input  logic       line_error_i,
  input  logic [1:0] slot_sel_i,
  input  logic [1:0] new_status_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_res_o,
  output logic [2:0] reply_o,
  output logic [1:0] reply_status_o,
  output logic [1:0] slot_o,
  output logic [2:0] command_o,
  output logic [2:0] job_o,
  output logic [7:0] param_first_o,
  output logic [7:0] param_second_o,
  output logic [7:0] param_third_o
);
  import mdbsfr_pkg::*;

  logic [2:0] code_reset_q, code_switch_q, code_control_q;
  logic [2:0] code_poll_q, code_column_q, code_status_q;

  phase_e     phase_q, phase_d;
  logic [5:0] count_q, count_d;
  logic [7:0] sum_q, sum_d;
  logic [1:0] cur_slot_q, cur_slot_d;
  logic [2:0] cur_cmd_q, cur_cmd_d;
  logic [7:0] payload_q [3];
  logic [7:0] payload_d [3];
  logic [1:0] slot_status_q [4];
  logic [1:0] slot_status_d [4];
  logic [1:0] sent_status_q [4];
  logic [1:0] sent_status_d [4];

  logic       out_valid_q;
  logic [2:0] event_q, event_d;
  logic [2:0] reply_q, reply_d;
  logic [1:0] rstat_q, rstat_d;
  logic [1:0] slot_q, slot_d;
  logic [2:0] cmd_q, cmd_d;
  logic [2:0] job_q, job_d;
  logic [7:0] p0_q, p1_q, p2_q;

  logic       in_fire;
  logic       bus_byte;
  logic       addr_hit;
  logic [1:0] hit_slot;
  cls_e       cls;
  logic [6:0] cnt_next;
  logic       overflow;
  logic       at_end;
  logic       sum_ok;
  logic [1:0] cur_status;
  logic       frame;
  logic       params;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign bus_byte    = in_fire && !kind_i && !line_error_i;

  always_comb begin
    addr_hit = 1'b0;
    hit_slot = 2'd0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_addr(2'(i)) == (rx_byte_i & ADDR_MASK)) begin
        addr_hit = 1'b1;
        hit_slot = 2'(i);
      end
    end
  end

  always_comb begin
    if (cur_cmd_q == code_reset_q) begin
      cls = CLS_RESET;
    end else if (cur_cmd_q == code_switch_q) begin
      cls = CLS_SWITCH;
    end else if (cur_cmd_q == code_control_q) begin
      cls = CLS_CONTROL;
    end else if (cur_cmd_q == code_poll_q) begin
      cls = CLS_POLL;
    end else if (cur_cmd_q == code_column_q) begin
      cls = CLS_COLUMN;
    end else if (cur_cmd_q == code_status_q) begin
      cls = CLS_STATUS;
    end else begin
      cls = CLS_NONE;
    end
  end

  assign cnt_next   = {1'b0, count_q} + 7'd1;
  assign overflow   = cnt_next >= 7'(FRAME_LIMIT);
  assign sum_ok     = sum_q == rx_byte_i;
  assign cur_status = slot_status_q[cur_slot_q];

  always_comb begin
    case (cls)
      CLS_NONE:    at_end = 1'b0;
      CLS_SWITCH:  at_end = cnt_next >= 7'd4;
      CLS_CONTROL: at_end = cnt_next >= 7'd6;
      default:     at_end = cnt_next >= 7'd2;
    endcase
  end

  // Link phase
  always_comb begin
    phase_d = phase_q;
    if (bus_byte) begin
      case (phase_q)
        PH_IDLE: begin
          if (mode_bit_i && addr_hit) phase_d = PH_RECV;
        end
        PH_RECV: begin
          if (!mode_bit_i) begin
            if (overflow) begin
              phase_d = PH_IDLE;
            end else if (at_end) begin
              phase_d = sum_ok ? PH_ACK : PH_IDLE;
            end
          end
        end
        default: begin
          if (!mode_bit_i) phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Frame datapath, slot status and result
  always_comb begin
    count_d       = count_q;
    sum_d         = sum_q;
    cur_slot_d    = cur_slot_q;
    cur_cmd_d     = cur_cmd_q;
    payload_d     = payload_q;
    slot_status_d = slot_status_q;
    sent_status_d = sent_status_q;
    event_d       = EV_NONE;
    reply_d       = RP_NONE;
    rstat_d       = STATUS_IDLE;
    job_d         = JOB_NONE;
    frame         = 1'b0;
    params        = 1'b0;
    if (kind_i) begin
      if ({1'b0, slot_sel_i} < 3'(SLOT_COUNT)) slot_status_d[slot_sel_i] = new_status_i;
    end else if (line_error_i) begin
      event_d = EV_IGNORED;
    end else if (phase_q == PH_IDLE) begin
      event_d = EV_IGNORED;
      if (mode_bit_i && addr_hit) begin
        count_d    = 6'd1;
        sum_d      = rx_byte_i;
        cur_slot_d = hit_slot;
        cur_cmd_d  = rx_byte_i[2:0];
        payload_d  = '{default: 8'd0};
        event_d    = EV_ADDRESS;
        frame      = 1'b1;
      end
    end else if (mode_bit_i) begin
      event_d = EV_IGNORED;
    end else begin
      case (phase_q)
        PH_RECV: begin
          frame   = 1'b1;
          count_d = cnt_next[5:0];
          if (cnt_next >= 7'd2 && cnt_next <= 7'd4) begin
            payload_d[2'(cnt_next - 7'd2)] = rx_byte_i;
          end
          if (overflow) begin
            event_d = EV_OVERFLOW;
          end else if (at_end) begin
            if (sum_ok) begin
              event_d = EV_FRAME_OK;
              params  = 1'b1;
              case (cls)
                CLS_POLL: begin
                  sent_status_d[cur_slot_q] = cur_status;
                  reply_d = RP_STATUS;
                  rstat_d = cur_status;
                end
                CLS_COLUMN: begin
                  reply_d = RP_HOST;
                  job_d   = JOB_COLUMN;
                end
                CLS_STATUS: begin
                  reply_d = RP_HOST;
                  job_d   = JOB_STATUS;
                end
                default: begin
                  if (cur_status == STATUS_BUSY) begin
                    reply_d = RP_NAK;
                  end else begin
                    slot_status_d[cur_slot_q] = STATUS_BUSY;
                    reply_d = RP_ACK;
                    job_d   = (cls == CLS_RESET)  ? JOB_RESET :
                              (cls == CLS_SWITCH) ? JOB_SWITCH : JOB_CONTROL;
                  end
                end
              endcase
            end else begin
              event_d = EV_CSUM_BAD;
            end
          end else begin
            sum_d   = sum_q + rx_byte_i;
            event_d = EV_DATA;
          end
        end
        PH_ACK: begin
          if (rx_byte_i == ACK_BYTE) begin
            event_d = EV_ACK_SEEN;
            frame   = 1'b1;
            if (cls == CLS_POLL && sent_status_q[cur_slot_q] != STATUS_BUSY) begin
              slot_status_d[cur_slot_q] = STATUS_IDLE;
              sent_status_d[cur_slot_q] = STATUS_IDLE;
            end
          end else begin
            event_d = EV_IGNORED;
          end
        end
        default: begin
          event_d = EV_IGNORED;
        end
      endcase
    end
    slot_d = frame ? cur_slot_d : 2'd0;
    cmd_d  = frame ? cur_cmd_d : 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_reset_q   <= 3'd0;
      code_switch_q  <= 3'd1;
      code_control_q <= 3'd2;
      code_poll_q    <= 3'd3;
      code_column_q  <= 3'd4;
      code_status_q  <= 3'd5;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CODE_RESET:   code_reset_q   <= cfg_data_i;
        CFG_CODE_SWITCH:  code_switch_q  <= cfg_data_i;
        CFG_CODE_CONTROL: code_control_q <= cfg_data_i;
        CFG_CODE_POLL:    code_poll_q    <= cfg_data_i;
        CFG_CODE_COLUMN:  code_column_q  <= cfg_data_i;
        CFG_CODE_STATUS:  code_status_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      count_q       <= 6'd0;
      sum_q         <= 8'd0;
      cur_slot_q    <= 2'd0;
      cur_cmd_q     <= 3'd0;
      payload_q     <= '{default: 8'd0};
      slot_status_q <= '{default: STATUS_IDLE};
      sent_status_q <= '{default: STATUS_IDLE};
    end else if (in_fire) begin
      phase_q       <= phase_d;
      count_q       <= count_d;
      sum_q         <= sum_d;
      cur_slot_q    <= cur_slot_d;
      cur_cmd_q     <= cur_cmd_d;
      payload_q     <= payload_d;
      slot_status_q <= slot_status_d;
      sent_status_q <= sent_status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      event_q <= event_d;
      reply_q <= reply_d;
      rstat_q <= rstat_d;
      slot_q  <= slot_d;
      cmd_q   <= cmd_d;
      job_q   <= job_d;
      p0_q    <= params ? payload_d[0] : 8'd0;
      p1_q    <= params ? payload_d[1] : 8'd0;
      p2_q    <= params ? payload_d[2] : 8'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = event_q;
  assign reply_o        = reply_q;
  assign reply_status_o = rstat_q;
  assign slot_o         = slot_q;
  assign command_o      = cmd_q;
  assign job_o          = job_q;
  assign param_first_o  = p0_q;
  assign param_second_o = p1_q;
  assign param_third_o  = p2_q;

endmodule

/* rtl/mdbsfr_checker.sv */
// ----------------------------------------------------------------------------
// MDB slave frame receiver checker
// Port-level assertions on the receiver, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mdbsfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] event_res_o,
  input logic [2:0] reply_o,
  input logic [1:0] slot_o,
  input logic [2:0] command_o,
  input logic [2:0] job_o,
  input logic [7:0] param_first_o
);
  import mdbsfr_pkg::*;

  `ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)
  `ASSERT_IMPL(a_result_held, clk_i, rst_ni,
               out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o))
  `ASSERT_NEVER(a_reply_needs_frame, clk_i, rst_ni,
                out_valid_o && (reply_o != RP_NONE || job_o != JOB_NONE ||
                                param_first_o != 8'd0) && event_res_o != EV_FRAME_OK)
  `ASSERT_NEVER(a_no_frame_fields, clk_i, rst_ni,
                out_valid_o && (event_res_o == EV_NONE || event_res_o == EV_IGNORED) &&
                (slot_o != 2'd0 || command_o != 3'd0))

endmodule

bind mdb_slave_frame_receiver_top mdbsfr_checker u_mdbsfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .event_res_o   (event_res_o),
  .reply_o       (reply_o),
  .slot_o        (slot_o),
  .command_o     (command_o),
  .job_o         (job_o),
  .param_first_o (param_first_o)
);
